@@ design/mrls_pkg.sv @@
// Shared constants, codes and types for the modem response line splitter.
package mrls_pkg;

   localparam int MAX_LINE   = 64;
   localparam int IDX_W      = $clog2(MAX_LINE);
   localparam int CNT_W      = $clog2(MAX_LINE + 1);
   localparam int CHAR_W     = 8;
   localparam int KIND_W     = 2;
   localparam int LEN_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROMPT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

   localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_GT = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_SP = 8'h20;

   // register word index, taken from paddr[2]
   localparam logic REG_PROMPT_ENABLE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // apply the incoming byte
      logic emit;     // load the next buffered character into the output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;      // output register empty or draining this cycle
      logic replay_start;  // accepted byte ends a non-empty line
      logic last;          // current replay character is the final one
   } status_type;

endpackage

@@ design/mrls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mrls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/mrls_ctrl.sv @@
// Controller state machine: byte intake versus line replay.
module mrls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mrls_pkg::status_type status,
   output mrls_pkg::cmd_type    cmd
);

   mrls_pkg::state_type state_ff, state_in;

   always_comb begin
      req_ready  = (state_ff == mrls_pkg::ST_IDLE) && status.out_free;
      cmd.accept = req_valid && req_ready;
      cmd.emit   = (state_ff == mrls_pkg::ST_EMIT) && status.out_free;
      state_in   = state_ff;
      unique case (state_ff)
         mrls_pkg::ST_IDLE: begin
            if (cmd.accept && status.replay_start) begin
               state_in = mrls_pkg::ST_EMIT;
            end
         end
         mrls_pkg::ST_EMIT: begin
            if (cmd.emit && status.last) begin
               state_in = mrls_pkg::ST_IDLE;
            end
         end
         default: state_in = mrls_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/mrls_dp.sv @@
// Datapath: line state, line store, replay pointer and output register.
module mrls_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  mrls_pkg::cmd_type                 cmd,
   output mrls_pkg::status_type              status,
   input  logic [mrls_pkg::CHAR_W-1:0]       rx_byte,
   input  logic                              cfg_we,
   input  logic                              cfg_prompt,
   output logic                              prompt_enable,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mrls_pkg::KIND_W-1:0]       rsp_token_kind,
   output logic [mrls_pkg::CHAR_W-1:0]       rsp_token_char,
   output logic [mrls_pkg::LEN_W-1:0]        rsp_token_length,
   output logic                              rsp_token_last
);

   logic [mrls_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       discard_ff, discard_in;
   logic                       skip_ff, skip_in;
   logic                       prompt_ff, prompt_in;
   logic [mrls_pkg::IDX_W-1:0] idx_ff, idx_in;

   logic                        valid_ff, valid_in;
   logic [mrls_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [mrls_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [mrls_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                        last_ff, last_in;

   logic                        load;
   logic                        wr_en, rd_en;
   logic [mrls_pkg::IDX_W-1:0]  rd_addr;
   logic [mrls_pkg::CHAR_W-1:0] rd_data;
   logic                        is_term, is_sp, is_gt;
   logic                        replay_go;
   logic [mrls_pkg::CNT_W-1:0]  idx_next;

   assign is_term  = (rx_byte == mrls_pkg::CH_CR) || (rx_byte == mrls_pkg::CH_LF);
   assign is_sp    = (rx_byte == mrls_pkg::CH_SP);
   assign is_gt    = (rx_byte == mrls_pkg::CH_GT);
   assign idx_next = mrls_pkg::CNT_W'(idx_ff) + 1'b1;

   assign status.out_free     = !valid_ff || rsp_ready;
   assign status.replay_start = replay_go;
   assign status.last         = (idx_next == count_ff);

   always_comb begin
      count_in   = count_ff;
      discard_in = discard_ff;
      skip_in    = skip_ff;
      prompt_in  = prompt_ff;
      idx_in     = idx_ff;
      load       = 1'b0;
      kind_in    = kind_ff;
      char_in    = char_ff;
      len_in     = len_ff;
      last_in    = last_ff;
      wr_en      = 1'b0;
      replay_go  = 1'b0;

      if (cmd.accept) begin
         skip_in = 1'b0;
         priority if (skip_ff && is_sp) begin
            // space after a prompt is dropped
         end else if (discard_ff) begin
            if (is_term) begin
               discard_in = 1'b0;
               count_in   = '0;
               load       = 1'b1;
               kind_in    = mrls_pkg::KIND_OVERFLOW;
               char_in    = '0;
               len_in     = '0;
               last_in    = 1'b1;
            end
         end else if (is_term) begin
            if (count_ff != '0) begin
               replay_go = 1'b1;
               idx_in    = '0;
            end
         end else if (prompt_ff && is_gt && (count_ff == '0)) begin
            load    = 1'b1;
            kind_in = mrls_pkg::KIND_PROMPT;
            char_in = mrls_pkg::CH_GT;
            len_in  = mrls_pkg::LEN_W'(1);
            last_in = 1'b1;
            skip_in = 1'b1;
         end else if (count_ff >= mrls_pkg::CNT_W'(mrls_pkg::MAX_LINE)) begin
            discard_in = 1'b1;
            count_in   = '0;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.emit) begin
         load    = 1'b1;
         kind_in = mrls_pkg::KIND_CHAR;
         char_in = rd_data;
         len_in  = mrls_pkg::LEN_W'(count_ff);
         last_in = status.last;
         if (status.last) begin
            count_in = '0;
         end else begin
            idx_in = idx_next[mrls_pkg::IDX_W-1:0];
         end
      end

      if (cfg_we) begin
         prompt_in = cfg_prompt;
         if (!cfg_prompt) begin
            skip_in = 1'b0;
         end
      end

      valid_in = load || (valid_ff && !rsp_ready);
   end

   // prefetch: address 0 at line end, then one ahead of each emitted char
   assign rd_en   = replay_go || (cmd.emit && !status.last);
   assign rd_addr = replay_go ? '0 : idx_next[mrls_pkg::IDX_W-1:0];

   mrls_ram #(
      .WIDTH(mrls_pkg::CHAR_W),
      .DEPTH(mrls_pkg::MAX_LINE)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[mrls_pkg::IDX_W-1:0]),
      .wr_data(rx_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         discard_ff <= 1'b0;
         skip_ff    <= 1'b0;
         prompt_ff  <= 1'b0;
         idx_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         discard_ff <= discard_in;
         skip_ff    <= skip_in;
         prompt_ff  <= prompt_in;
         idx_ff     <= idx_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      len_ff  <= len_in;
      last_ff <= last_in;
   end

   assign prompt_enable    = prompt_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_token_char   = char_ff;
   assign rsp_token_length = len_ff;
   assign rsp_token_last   = last_ff;

`ifndef NO_ASSERTIONS
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (count_ff != '0))
      else $error("replay with empty line");

   a_discard_empty: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (count_ff == '0))
      else $error("line holds characters while discarding");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mrls_pkg::CNT_W'(mrls_pkg::MAX_LINE))
      else $error("line count past depth");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> valid_ff && $stable(char_ff) && $stable(kind_ff))
      else $error("output word overwritten while stalled");
`endif

endmodule

@@ design/modem_response_line_splitter_core.sv @@
// Top level of the modem response line splitter: ports, CSR decode, controller and datapath.
// Timing: a prompt or overflow word is visible the cycle after its byte is accepted;
//   a line end reads line RAM address 0, and the registered read data enters the output when free.
// Throughput: bytes are accepted while idle and the output is free; a line replays one character
//   per cycle while the output is not stalled, set by the single read port of the line RAM.
// Reset (synchronous, active high) empties the line, leaves discard and prompt-skip off and
//   disables prompt detection; line RAM contents are not cleared and need no clearing pass.
module modem_response_line_splitter_core (
   input  logic                                clock,
   input  logic                                reset,
   // received byte word
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mrls_pkg::CHAR_W-1:0]         req_rx_byte,
   input  logic                                req_chunk_end,
   // token word
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mrls_pkg::KIND_W-1:0]         rsp_token_kind,
   output logic [mrls_pkg::CHAR_W-1:0]         rsp_token_char,
   output logic [mrls_pkg::LEN_W-1:0]          rsp_token_length,
   output logic                                rsp_token_last,
   // APB-style CSR port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mrls_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mrls_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mrls_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   mrls_pkg::cmd_type    cmd;
   mrls_pkg::status_type status;
   logic                 cfg_we;
   logic                 prompt_enable;
   logic                 reg_hit;

   // chunk_end marks software feed boundaries only; parsing ignores it
   logic                 unused_chunk_end;
   assign unused_chunk_end = req_chunk_end;

   // single register at word 0; other words read zero and ignore writes
   assign reg_hit    = (csr_paddr[2] == mrls_pkg::REG_PROMPT_ENABLE);
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && reg_hit;
   assign csr_prdata = reg_hit ? mrls_pkg::CSR_DATA_W'(prompt_enable) : '0;

   mrls_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   mrls_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rx_byte         (req_rx_byte),
      .cfg_we          (cfg_we),
      .cfg_prompt      (csr_pwdata[0]),
      .prompt_enable   (prompt_enable),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_char  (rsp_token_char),
      .rsp_token_length(rsp_token_length),
      .rsp_token_last  (rsp_token_last)
   );

endmodule
